### rtl/segment_ring_collision_classify_macros.svh
// Assertion macros used by the segment ring classifier checker
`ifndef SEGMENT_RING_COLLISION_CLASSIFY_MACROS_SVH
`define SEGMENT_RING_COLLISION_CLASSIFY_MACROS_SVH

// ante implies cons in the same cycle
`define SRCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies that $past(cond, n) is true
`define SRCC_ASSERT_PAST(label, clk, rst_n, ante, cond, n, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> $past(cond, n)) \
        else $error(msg);

`endif

### rtl/srcc_pkg.sv
// Shared types and constants of the segment ring classifier
package srcc_pkg;

    typedef enum logic [1:0] {
        VERDICT_MISS      = 2'd0,
        VERDICT_HIT       = 2'd1,
        VERDICT_HIT_START = 2'd2
    } t_verdict;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Z = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS   = 2'd2;

    localparam int RADIUS_RESET = 12800;

    // request to result strobe, in cycles
    localparam int PIPE_LAT = 7;

endpackage

### rtl/segment_ring_collision_classify.sv
// Segment versus ring collision classifier, seven stage pipeline
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------------
//  request  | start, busy       | i_start_x, i_start_z, i_end_x, i_end_z, i_offset
//  result   | o_done            | o_verdict
//  config   | i_cfg_we          | i_cfg_idx, i_cfg_wdata
//
// One request per cycle; the result strobe o_done is the last bit of the valid shift register.
// Latency is set by the squaring chain: differences, products, sums, magnitude,
// split partial products of the 4*COORD_BITS+2 wide terms, their sum, compare.
// busy stays low; the result cannot be held off and is shown for one cycle.
// Synchronous active low reset clears the valid bits and resets the configuration registers.
module segment_ring_collision_classify
    import srcc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  i_start_x,
    input  logic signed [COORD_BITS-1:0]  i_start_z,
    input  logic signed [COORD_BITS-1:0]  i_end_x,
    input  logic signed [COORD_BITS-1:0]  i_end_z,
    input  logic        [COORD_BITS-2:0]  i_offset,
    output logic                          o_done,
    output logic        [1:0]             o_verdict,
    input  logic                          i_cfg_we,
    input  logic        [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic        [COORD_BITS-1:0]  i_cfg_wdata
);

    localparam int CB  = COORD_BITS;
    localparam int W   = CB + 1;        // coordinate difference
    localparam int XW  = 2 * W;         // signed product, cross, dot
    localparam int SW  = 2 * CB + 1;    // sum of two squares, |cross|
    localparam int RW  = 2 * CB;        // squared radius
    localparam int H   = CB + 1;        // low half of a split operand
    localparam int LHW = 4 * CB + 2;    // cross^2 and rmax^2 * seg^2

    // configuration
    logic signed [CB-1:0] r_center_x;
    logic signed [CB-1:0] r_center_z;
    logic        [CB-2:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_z <= '0;
            r_radius   <= (CB-1)'(RADIUS_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X: r_center_x <= i_cfg_wdata;
                CFG_CENTER_Z: r_center_z <= i_cfg_wdata;
                CFG_RADIUS:   r_radius   <= i_cfg_wdata[CB-2:0];
                default: ;
            endcase
        end
    end

    logic       w_accept;
    logic [6:0] r_vld;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[5:0], w_accept};
        end
    end

    // stage 1: differences and ring bounds
    logic signed [W-1:0]  n1_lx, n1_lz, n1_ax, n1_az, n1_bx, n1_bz;
    logic        [CB-1:0] n1_rmax;
    logic signed [CB-1:0] n1_rmin;
    logic        [CB-2:0] n1_rminp;
    logic signed [W-1:0]  r1_lx, r1_lz, r1_ax, r1_az, r1_bx, r1_bz;
    logic        [CB-1:0] r1_rmax;
    logic        [CB-2:0] r1_rminp;
    logic                 r1_zero;

    always_comb begin
        n1_lx   = $signed({i_start_x[CB-1], i_start_x}) - $signed({i_end_x[CB-1], i_end_x});
        n1_lz   = $signed({i_start_z[CB-1], i_start_z}) - $signed({i_end_z[CB-1], i_end_z});
        n1_ax   = $signed({i_start_x[CB-1], i_start_x})
                - $signed({r_center_x[CB-1], r_center_x});
        n1_az   = $signed({i_start_z[CB-1], i_start_z})
                - $signed({r_center_z[CB-1], r_center_z});
        n1_bx   = $signed({i_end_x[CB-1], i_end_x}) - $signed({r_center_x[CB-1], r_center_x});
        n1_bz   = $signed({i_end_z[CB-1], i_end_z}) - $signed({r_center_z[CB-1], r_center_z});
        n1_rmax = {1'b0, r_radius} + {1'b0, i_offset};
        n1_rmin = $signed({1'b0, r_radius}) - $signed({1'b0, i_offset});
        // inner bound only matters when positive
        if (!n1_rmin[CB-1] && (n1_rmin != '0)) begin
            n1_rminp = n1_rmin[CB-2:0];
        end else begin
            n1_rminp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_lx    <= n1_lx;
        r1_lz    <= n1_lz;
        r1_ax    <= n1_ax;
        r1_az    <= n1_az;
        r1_bx    <= n1_bx;
        r1_bz    <= n1_bz;
        r1_rmax  <= n1_rmax;
        r1_rminp <= n1_rminp;
        r1_zero  <= (n1_lx == '0) && (n1_lz == '0);
    end

    // stage 2: products
    logic signed [XW-1:0] r2_lxx, r2_lzz, r2_axx, r2_azz, r2_bxx, r2_bzz;
    logic signed [XW-1:0] r2_lxaz, r2_lzax, r2_axlx, r2_azlz, r2_bxlx, r2_bzlz;
    logic        [RW-1:0] r2_rmax2;
    logic        [RW-3:0] r2_rmin2;
    logic                 r2_zero;

    always_ff @(posedge i_clk) begin
        r2_lxx   <= r1_lx * r1_lx;
        r2_lzz   <= r1_lz * r1_lz;
        r2_axx   <= r1_ax * r1_ax;
        r2_azz   <= r1_az * r1_az;
        r2_bxx   <= r1_bx * r1_bx;
        r2_bzz   <= r1_bz * r1_bz;
        r2_lxaz  <= r1_lx * r1_az;
        r2_lzax  <= r1_lz * r1_ax;
        r2_axlx  <= r1_ax * r1_lx;
        r2_azlz  <= r1_az * r1_lz;
        r2_bxlx  <= r1_bx * r1_lx;
        r2_bzlz  <= r1_bz * r1_lz;
        r2_rmax2 <= r1_rmax * r1_rmax;
        r2_rmin2 <= r1_rminp * r1_rminp;
        r2_zero  <= r1_zero;
    end

    // stage 3: squared lengths, cross and dot products
    logic        [SW-1:0] r3_seg2, r3_d2s, r3_d2e;
    logic signed [XW-1:0] r3_cross, r3_dot1, r3_dot2;
    logic        [RW-1:0] r3_rmax2, r3_rmin2;
    logic                 r3_zero;

    always_ff @(posedge i_clk) begin
        r3_seg2  <= r2_lxx[SW-1:0] + r2_lzz[SW-1:0];
        r3_d2s   <= r2_axx[SW-1:0] + r2_azz[SW-1:0];
        r3_d2e   <= r2_bxx[SW-1:0] + r2_bzz[SW-1:0];
        r3_cross <= r2_lxaz - r2_lzax;
        r3_dot1  <= r2_axlx + r2_azlz;
        r3_dot2  <= r2_bxlx + r2_bzlz;
        r3_rmax2 <= r2_rmax2;
        r3_rmin2 <= {2'b00, r2_rmin2};
        r3_zero  <= r2_zero;
    end

    // stage 4: end point tests and |cross|
    logic signed [XW-1:0] n4_neg;
    logic        [SW-1:0] n4_cmag;
    logic                 n4_both_out, n4_same_side, n4_both_in, n4_start_in;
    logic        [SW-1:0] r4_cmag, r4_seg2;
    logic        [RW-1:0] r4_rmax2;
    logic                 r4_miss, r4_start_in;

    always_comb begin
        n4_neg       = -r3_cross;
        n4_cmag      = r3_cross[XW-1] ? n4_neg[SW-1:0] : r3_cross[SW-1:0];
        n4_both_out  = (r3_d2s > SW'(r3_rmax2)) && (r3_d2e > SW'(r3_rmax2));
        // an end abeam of the center is on neither side
        n4_same_side = (!r3_dot1[XW-1] && (r3_dot1 != '0) && !r3_dot2[XW-1] && (r3_dot2 != '0))
                    || (r3_dot1[XW-1] && r3_dot2[XW-1]);
        n4_both_in   = (r3_d2s < SW'(r3_rmin2)) && (r3_d2e < SW'(r3_rmin2));
        n4_start_in  = (r3_d2s <= SW'(r3_rmax2)) && (r3_d2s >= SW'(r3_rmin2));
    end

    always_ff @(posedge i_clk) begin
        r4_cmag     <= n4_cmag;
        r4_seg2     <= r3_seg2;
        r4_rmax2    <= r3_rmax2;
        r4_miss     <= r3_zero || (n4_both_out && n4_same_side) || n4_both_in;
        r4_start_in <= n4_start_in;
    end

    // stage 5: partial products of cross^2 and rmax^2 * seg^2
    logic [CB-1:0]     w5_chi, w5_a1, w5_a0, w5_b1;
    logic [H-1:0]      w5_clo, w5_b0;
    logic [2*CB-1:0]   r5_hh, r5_a1b1, r5_a0b1;
    logic [2*CB:0]     r5_hl, r5_a1b0, r5_a0b0;
    logic [2*H-1:0]    r5_ll;
    logic              r5_miss, r5_start_in;

    assign w5_chi = r4_cmag[SW-1:H];
    assign w5_clo = r4_cmag[H-1:0];
    assign w5_a1  = r4_rmax2[RW-1:CB];
    assign w5_a0  = r4_rmax2[CB-1:0];
    assign w5_b1  = r4_seg2[SW-1:H];
    assign w5_b0  = r4_seg2[H-1:0];

    always_ff @(posedge i_clk) begin
        r5_hh       <= w5_chi * w5_chi;
        r5_hl       <= w5_chi * w5_clo;
        r5_ll       <= w5_clo * w5_clo;
        r5_a1b1     <= w5_a1 * w5_b1;
        r5_a1b0     <= w5_a1 * w5_b0;
        r5_a0b1     <= w5_a0 * w5_b1;
        r5_a0b0     <= w5_a0 * w5_b0;
        r5_miss     <= r4_miss;
        r5_start_in <= r4_start_in;
    end

    // stage 6: recombine
    logic [LHW-1:0] r6_lhs, r6_rhs;
    logic           r6_miss, r6_start_in;

    always_ff @(posedge i_clk) begin
        r6_lhs      <= (LHW'(r5_hh) << (2 * H)) + (LHW'(r5_hl) << (H + 1)) + LHW'(r5_ll);
        r6_rhs      <= (LHW'(r5_a1b1) << (CB + H)) + (LHW'(r5_a1b0) << CB)
                     + (LHW'(r5_a0b1) << H) + LHW'(r5_a0b0);
        r6_miss     <= r5_miss;
        r6_start_in <= r5_start_in;
    end

    // stage 7: line distance test and verdict
    t_verdict n7_verdict;
    t_verdict r_verdict;

    always_comb begin
        if (r6_miss || (r6_lhs > r6_rhs)) begin
            n7_verdict = VERDICT_MISS;
        end else if (r6_start_in) begin
            n7_verdict = VERDICT_HIT_START;
        end else begin
            n7_verdict = VERDICT_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n7_verdict;
    end

    assign o_done    = r_vld[6];
    assign o_verdict = r_verdict;

endmodule

### rtl/srcc_checker.sv
// Port level checks of the segment ring classifier, bound to the top level
`include "segment_ring_collision_classify_macros.svh"

module srcc_checker
    import srcc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [COORD_BITS-1:0]  i_start_x,
    input logic signed [COORD_BITS-1:0]  i_start_z,
    input logic signed [COORD_BITS-1:0]  i_end_x,
    input logic signed [COORD_BITS-1:0]  i_end_z,
    input logic                          o_done,
    input logic        [1:0]             o_verdict
);

    logic w_req;
    logic w_zero_len;

    assign w_req      = start && !busy;
    assign w_zero_len = w_req && (i_start_x == i_end_x) && (i_start_z == i_end_z);

    `SRCC_ASSERT_IMPL(a_verdict_code, i_clk, i_rst_n, o_done, (o_verdict == VERDICT_MISS) || (o_verdict == VERDICT_HIT) || (o_verdict == VERDICT_HIT_START), "illegal verdict code")
    `SRCC_ASSERT_PAST(a_done_has_req, i_clk, i_rst_n, o_done, w_req, PIPE_LAT, "result without request")
    `SRCC_ASSERT_IMPL(a_zero_len_miss, i_clk, i_rst_n, o_done && $past(w_zero_len, PIPE_LAT), o_verdict == VERDICT_MISS, "zero length segment hit")

endmodule

bind segment_ring_collision_classify srcc_checker #(
    .COORD_BITS (COORD_BITS)
) u_srcc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_start_x (i_start_x),
    .i_start_z (i_start_z),
    .i_end_x   (i_end_x),
    .i_end_z   (i_end_z),
    .o_done    (o_done),
    .o_verdict (o_verdict)
);

### tb/tb_top.sv
// Self-checking testbench for the segment versus ring collision classifier
`timescale 1ns / 100ps

module tb_top;
    import srcc_pkg::*;

    localparam int CB = 24;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef logic signed [127:0] t_wide;

    // Expected verdicts, oldest first
    class verdict_board;
        t_verdict awaited[$];
        int errors;
        int checked;
        int tally[3];

        function void note(t_verdict v);
            awaited.push_back(v);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(logic [1:0] got);
            t_verdict want;
            if (awaited.size() == 0) begin
                report($sformatf("verdict %0d with no request pending", got));
            end else begin
                want = awaited.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("request %0d: verdict %0d, expected %0d",
                                     checked, got, want));
                else
                    tally[want]++;
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic signed [CB-1:0]   i_start_x = '0;
    logic signed [CB-1:0]   i_start_z = '0;
    logic signed [CB-1:0]   i_end_x = '0;
    logic signed [CB-1:0]   i_end_z = '0;
    logic        [CB-2:0]   i_offset = '0;
    logic                   o_done;
    logic        [1:0]      o_verdict;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic        [CB-1:0]   i_cfg_wdata = '0;

    // Our copy of the ring registers
    logic signed [CB-1:0]   ring_cx = '0;
    logic signed [CB-1:0]   ring_cz = '0;
    logic        [CB-2:0]   ring_rad = (CB-1)'(RADIUS_RESET);

    verdict_board board = new;
    int settings_run = 1;

    segment_ring_collision_classify #(.COORD_BITS(CB)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_start_x   (i_start_x),
        .i_start_z   (i_start_z),
        .i_end_x     (i_end_x),
        .i_end_z     (i_end_z),
        .i_offset    (i_offset),
        .o_done      (o_done),
        .o_verdict   (o_verdict),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Exact classification with wide signed arithmetic, squared distances only
    function automatic t_verdict classify_segment(logic signed [CB-1:0] sx,
                                                  logic signed [CB-1:0] sz,
                                                  logic signed [CB-1:0] ex,
                                                  logic signed [CB-1:0] ez,
                                                  logic [CB-2:0] off);
        t_wide psx, psz, pex, pez, pcx, pcz, woff, wrad;
        t_wide lx, lz, ax, az, bx, bz, rmax, rmin;
        t_wide seg2, rmax2, rmin2, cr, d2s, d2e, dot_s, dot_e;
        psx = t_wide'(sx);
        psz = t_wide'(sz);
        pex = t_wide'(ex);
        pez = t_wide'(ez);
        pcx = t_wide'(ring_cx);
        pcz = t_wide'(ring_cz);
        woff = t_wide'(off);
        wrad = t_wide'(ring_rad);
        lx = psx - pex;
        lz = psz - pez;
        ax = psx - pcx;
        az = psz - pcz;
        bx = pex - pcx;
        bz = pez - pcz;
        rmax = wrad + woff;
        rmin = wrad - woff;
        if (lx == 0 && lz == 0)
            return VERDICT_MISS;
        seg2 = lx * lx + lz * lz;
        rmax2 = rmax * rmax;
        cr = lz * (-ax) + lx * az;
        if (cr * cr > rmax2 * seg2)
            return VERDICT_MISS;
        d2s = ax * ax + az * az;
        d2e = bx * bx + bz * bz;
        if (d2s > rmax2 && d2e > rmax2) begin
            dot_s = ax * lx + az * lz;
            dot_e = bx * lx + bz * lz;
            // an end abeam of the center (zero dot) is on neither side
            if ((dot_s > 0 && dot_e > 0) || (dot_s < 0 && dot_e < 0))
                return VERDICT_MISS;
        end
        if (rmin > 0) begin
            rmin2 = rmin * rmin;
            if (d2s < rmin2 && d2e < rmin2)
                return VERDICT_MISS;
        end else begin
            rmin2 = '0;
        end
        if (d2s <= rmax2 && d2s >= rmin2)
            return VERDICT_HIT_START;
        return VERDICT_HIT;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                board.note(classify_segment(i_start_x, i_start_z, i_end_x, i_end_z,
                                            i_offset));
            if (o_done)
                board.check(o_verdict);
        end
    end

    // Leaves start high; the caller lowers it or sends the next request
    task send_segment(int sx, int sz, int ex, int ez, int off);
        start <= 1'b1;
        i_start_x <= CB'(sx);
        i_start_z <= CB'(sz);
        i_end_x <= CB'(ex);
        i_end_z <= CB'(ez);
        i_offset <= (CB-1)'(off);
        do @(posedge i_clk); while (busy);
    endtask

    task idle_input(int cycles);
        start <= 1'b0;
        i_start_x <= CB'($urandom);
        i_start_z <= CB'($urandom);
        i_end_x <= CB'($urandom);
        i_end_z <= CB'($urandom);
        i_offset <= (CB-1)'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task drain_results();
        start <= 1'b0;
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // Leaves the write enable high; program_ring lowers it after the last write
    task write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CENTER_X: ring_cx = data;
            CFG_CENTER_Z: ring_cz = data;
            CFG_RADIUS:   ring_rad = data[CB-2:0];
            default: ;
        endcase
    endtask

    task program_ring(int cx, int cz, int rad);
        write_reg(CFG_UNUSED, CB'($urandom));
        write_reg(CFG_CENTER_X, CB'(cx));
        write_reg(CFG_CENTER_Z, CB'(cz));
        // top data bit is beyond the radius width and must be ignored
        write_reg(CFG_RADIUS, {1'($urandom_range(0, 1)), rad[CB-2:0]});
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    function automatic int near_coord(longint base, longint span);
        return int'(base + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    task send_random_segment();
        int mode;
        int sx, sz, ex, ez;
        longint rad, off, span;
        mode = $urandom_range(0, 99);
        rad = longint'(ring_rad);
        if (mode < 8) begin
            send_segment($urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            case ($urandom_range(0, 9))
                0: off = 0;
                1: off = rad + $urandom_range(0, rad + 16);   // inner radius <= 0
                default: off = $urandom_range(0, rad / 4 + 16);
            endcase
            span = rad + off + rad / 2 + 64;
            sx = near_coord(longint'(ring_cx), span);
            sz = near_coord(longint'(ring_cz), span);
            if (mode < 14) begin
                ex = sx;
                ez = sz;
            end else if (mode < 40) begin
                ex = near_coord(longint'(sx), span / 8 + 1);
                ez = near_coord(longint'(sz), span / 8 + 1);
            end else begin
                ex = near_coord(longint'(ring_cx), span);
                ez = near_coord(longint'(ring_cz), span);
            end
            send_segment(sx, sz, ex, ez, int'(off));
        end
    endtask

    task run_random(int count, bit with_gaps);
        repeat (count) begin
            if (with_gaps && $urandom_range(0, 4) == 0)
                idle_input($urandom_range(1, 15));
            send_random_segment();
        end
    endtask

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset ring: center at origin, radius 50.0
        send_segment(100, 100, 100, 100, 256);              // zero length
        send_segment(0, 20000, 100, 20000, 256);            // line too far
        send_segment(-20000, 0, -15000, 0, 256);            // both outside, same side
        send_segment(-15000, 0, -20000, 0, 256);
        send_segment(-20000, 0, 20000, 0, 256);             // passes through
        send_segment(0, 0, 100, 0, 256);                    // both inside inner circle
        send_segment(12800, 0, 0, 0, 256);                  // start on circle
        send_segment(13056, 0, 20000, 0, 256);              // start on outer edge
        idle_input(3);
        send_segment(0, 0, 10, 0, 20000);                   // negative inner radius
        send_segment(20000, 12800, -20000, 12800, 0);       // tangent line
        send_segment(20000, 12800, 0, 12800, 0);            // end abeam of center
        send_segment(12544, 0, 0, 12544, 256);              // ends on inner edge
        send_segment(12543, 0, 0, 12543, 256);
        send_segment(13057, 0, 0, 13057, 256);
        send_segment(8388607, 8388607, -8388608, -8388608, 8388607);
        send_segment(-8388608, -8388608, 8388607, 8388607, 0);
        send_segment(-8388608, 8388607, 8388607, -8388608, 8388607);
        send_segment(8388607, -8388608, 8388607, 8388607, 0);
        send_segment(0, -8388608, 0, 8388607, 0);
        send_segment(0, 0, 0, 0, 8388607);
        run_random(200, 1'b1);
        drain_results();

        program_ring(-8388608, 8388607, 8388607);
        run_random(250, 1'b1);
        drain_results();

        program_ring(8388607, -8388608, 0);
        run_random(250, 1'b1);
        drain_results();

        program_ring(1000, -2000, 256);
        run_random(250, 1'b1);
        drain_results();

        program_ring($urandom, $urandom, $urandom_range(1, 4096));
        run_random(250, 1'b1);
        drain_results();

        // last stretch back to back
        program_ring($urandom, $urandom, $urandom);
        run_random(250, 1'b0);
        drain_results();

        $display("%0d verdicts checked over %0d ring settings", board.checked,
                 settings_run);
        $display("miss %0d, hit %0d, hit with start in band %0d",
                 board.tally[VERDICT_MISS], board.tally[VERDICT_HIT],
                 board.tally[VERDICT_HIT_START]);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
